FILE: rtl/afpni_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afpni_pkg
// Shared types and constants of the autofocus pixel neighbor interpolator.
// ----------------------------------------------------------------------------
package afpni_pkg;

  localparam int SMP_W  = 16;
  localparam int PIX_W  = 14;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 4;

  localparam logic [PIX_W-1:0]  PIX_MAX  = {PIX_W{1'b1}};
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(PIX_W - 1);

  localparam logic [KIND_W-1:0] KIND_CENTRE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd4;

  localparam logic CH_RED   = 1'b0;
  localparam logic CH_GREEN = 1'b1;

  typedef struct packed {
    logic upd;
    logic eval;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_step;
    logic wr;
    logic ch;
  } dp_cmd_t;

  typedef struct packed {
    logic dark;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/af_pixel_neighbor_interpolate_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af_pixel_neighbor_interpolate_unit
// Repairs an autofocus pixel from its nearest-blue neighbor.
// ----------------------------------------------------------------------------
// Centre, top, bottom and left pixels are stored as they are accepted and the
// input stays ready. Right neighbor: the dark test is evaluated, then per
// channel two multiplies, one sum and a 14-step serial divide run and the
// quotient is written, the dark path skipping these. No input is taken until
// the result is loaded into the free output register. Synchronous active-low
// reset clears black level, pixel store and control; output valid drops.
module af_pixel_neighbor_interpolate_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_data,    // black_level
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,    // red_in, green_in, blue_in
  input  wire logic [2:0]  in_tuser,    // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // red_out, green_out, blue_out, zero pad
  output logic [0:0]       out_tuser    // dark_path
);
  import afpni_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             out_free, out_load;
  logic             out_valid_r;
  logic [PIX_W-1:0] res_red, res_green;
  logic [SMP_W-1:0] res_blue;
  logic             res_dark;
  logic [47:0]      out_data_r;
  logic             out_dark_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  afpni_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  afpni_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_kind   (in_tuser),
    .in_red    (in_tdata[15:0]),
    .in_green  (in_tdata[31:16]),
    .in_blue   (in_tdata[47:32]),
    .cmd       (cmd),
    .status    (status),
    .res_red   (res_red),
    .res_green (res_green),
    .res_blue  (res_blue),
    .res_dark  (res_dark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {4'b0000, res_blue, res_green, res_red};
      out_dark_r <= res_dark;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dark_r;

  a_right_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_RIGHT |=> !in_tready)
    else $error("request taken while right neighbor in progress");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

  a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !in_tready)
    else $error("input accepted during result load");

endmodule
`default_nettype wire

FILE: rtl/afpni_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afpni_ctrl
// Sequencer: accepts pixels, runs the per-channel multiply and divide steps
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module afpni_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [afpni_pkg::KIND_W-1:0] in_kind,
  output logic                              in_ready,
  input  wire logic                         out_free,
  output logic                              out_load,
  input  wire afpni_pkg::dp_status_t        status,
  output afpni_pkg::dp_cmd_t                cmd
);
  import afpni_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MULA, S_MULB, S_SUM, S_DIV, S_WR, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic               ch_r, ch_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.upd = 1'b1;
          if (in_kind == KIND_RIGHT) state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.dark) begin
          state_nxt = S_EMIT;
        end else begin
          ch_nxt    = CH_RED;
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_WR;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (ch_r == CH_RED) begin
          ch_nxt    = CH_GREEN;
          state_nxt = S_MULA;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= CH_RED;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/afpni_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afpni_dp
// Datapath: centre and best-neighbor store, shared multiplier and a
// bit-serial restoring divider with saturation at the pixel maximum.
// ----------------------------------------------------------------------------
module afpni_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [afpni_pkg::PIX_W-1:0]  cfg_data,
  input  wire logic [afpni_pkg::KIND_W-1:0] in_kind,
  input  wire logic [afpni_pkg::SMP_W-1:0]  in_red,
  input  wire logic [afpni_pkg::SMP_W-1:0]  in_green,
  input  wire logic [afpni_pkg::SMP_W-1:0]  in_blue,
  input  wire afpni_pkg::dp_cmd_t           cmd,
  output afpni_pkg::dp_status_t             status,
  output logic [afpni_pkg::PIX_W-1:0]       res_red,
  output logic [afpni_pkg::PIX_W-1:0]       res_green,
  output logic [afpni_pkg::SMP_W-1:0]       res_blue,
  output logic                              res_dark
);
  import afpni_pkg::*;

  localparam int DIF_W  = SMP_W + 2;
  localparam int TRM_W  = DIF_W + 4;
  localparam int PRD_W  = 38;
  localparam int DEN_W  = SMP_W + 1 + 3;
  localparam int REM_W  = DEN_W + PIX_W - 1;
  localparam int DK_W   = DIF_W + 2;

  logic [PIX_W-1:0]  black_r;
  logic [SMP_W-1:0]  c_red_r, c_green_r, c_blue_r;
  logic [SMP_W-1:0]  b_red_r, b_green_r, b_blue_r, b_dist_r;
  logic signed [PRD_W-1:0] prod_r, acc_r;
  logic [REM_W-1:0]  rem_r, dsh_r;
  logic [PIX_W-1:0]  q_r;
  logic              sat_r;
  logic [PIX_W-1:0]  res_red_r, res_green_r;
  logic              dark_r;

  function automatic logic signed [DIF_W-1:0] sub_black(input logic [SMP_W-1:0] v,
                                                        input logic [PIX_W-1:0] b);
    sub_black = $signed({2'b00, v}) - $signed({4'b0000, b});
  endfunction

  function automatic logic [PIX_W-1:0] clip_dk(input logic signed [DK_W-1:0] x);
    if (x[DK_W-1]) clip_dk = '0;
    else if (x > $signed({{(DK_W-PIX_W){1'b0}}, PIX_MAX})) clip_dk = PIX_MAX;
    else clip_dk = x[PIX_W-1:0];
  endfunction

  logic [SMP_W-1:0]        blue_dist;
  logic [SMP_W:0]          thr;
  logic [SMP_W-1:0]        v_sel, pf_sel;
  logic signed [DIF_W-1:0] dv, pfd, dl, dn, dv_r, dv_g;
  logic signed [TRM_W-1:0] termb, mul_x;
  logic signed [DIF_W-1:0] mul_y;
  logic signed [TRM_W+DIF_W-1:0] product;
  logic signed [PRD_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [DEN_W+PIX_W-1:0]  lim;
  logic                    num_sat;
  logic signed [DK_W-1:0]  dk_r, dk_g;

  always_comb begin
    blue_dist = (in_blue > c_blue_r) ? in_blue - c_blue_r : c_blue_r - in_blue;
    thr    = {3'b000, black_r} + (SMP_W+1)'(16);
    status.dark = ({1'b0, c_blue_r} < thr) || ({1'b0, b_blue_r} < thr);

    v_sel  = (cmd.ch == CH_GREEN) ? c_green_r : c_red_r;
    pf_sel = (cmd.ch == CH_GREEN) ? b_green_r : b_red_r;
    dv     = sub_black(v_sel, black_r);
    pfd    = sub_black(pf_sel, black_r);
    dl     = sub_black(c_blue_r, black_r);
    dn     = sub_black(b_blue_r, black_r);
    termb  = $signed({dv, 4'b0000}) - $signed({{4{dv[DIF_W-1]}}, dv})
           + $signed({5'b00000, black_r, 3'b000});
    mul_x  = cmd.mul_a ? $signed({{4{pfd[DIF_W-1]}}, pfd}) : termb;
    mul_y  = cmd.mul_a ? dn : dl;
    product = mul_x * mul_y;

    num     = acc_r + prod_r;
    den     = {dl[SMP_W:0], 3'b000};
    lim     = {den, {PIX_W{1'b0}}};
    num_sat = num >= $signed({{(PRD_W-DEN_W-PIX_W){1'b0}}, lim});

    dv_r = sub_black(c_red_r, black_r);
    dv_g = sub_black(c_green_r, black_r);
    dk_r = $signed({dv_r, 2'b00}) + $signed({{(DK_W-PIX_W){1'b0}}, black_r});
    dk_g = $signed({dv_g, 2'b00}) + $signed({{(DK_W-PIX_W){1'b0}}, black_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r   <= '0;
      c_red_r   <= '0;
      c_green_r <= '0;
      c_blue_r  <= '0;
      b_red_r   <= '0;
      b_green_r <= '0;
      b_blue_r  <= '0;
      b_dist_r  <= '0;
    end else begin
      if (cfg_we) black_r <= cfg_data;
      if (cmd.upd) begin
        if (in_kind == KIND_CENTRE) begin
          c_red_r   <= in_red;
          c_green_r <= in_green;
          c_blue_r  <= in_blue;
        end else if (in_kind <= KIND_RIGHT) begin
          if (in_kind == KIND_TOP || b_dist_r > blue_dist) begin
            b_red_r   <= in_red;
            b_green_r <= in_green;
            b_blue_r  <= in_blue;
            b_dist_r  <= blue_dist;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dark_r <= status.dark;
      if (status.dark) begin
        res_red_r   <= clip_dk(dk_r);
        res_green_r <= clip_dk(dk_g);
      end
    end
    if (cmd.mul_a) prod_r <= product[PRD_W-1:0];
    if (cmd.mul_b) begin
      prod_r <= product[PRD_W-1:0];
      acc_r  <= {prod_r[PRD_W-3:0], 2'b00};
    end
    if (cmd.sum) begin
      q_r   <= '0;
      dsh_r <= {den, {(PIX_W-1){1'b0}}};
      sat_r <= num_sat && !num[PRD_W-1];
      if (num[PRD_W-1] || num_sat) rem_r <= '0;
      else rem_r <= num[REM_W-1:0];
    end
    if (cmd.div_step) begin
      dsh_r <= dsh_r >> 1;
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[PIX_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[PIX_W-2:0], 1'b0};
      end
    end
    if (cmd.wr) begin
      if (cmd.ch == CH_GREEN) res_green_r <= sat_r ? PIX_MAX : q_r;
      else res_red_r <= sat_r ? PIX_MAX : q_r;
    end
  end

  assign res_red   = res_red_r;
  assign res_green = res_green_r;
  assign res_blue  = c_blue_r;
  assign res_dark  = dark_r;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks af_pixel_neighbor_interpolate_unit. Five-pixel groups (center, then
// top, bottom, left and right neighbors), broken groups and stray pixels go
// in over a stream. A predictor tracks the nearest-blue neighbor and computes
// the repaired center red and green. The monitor compares each result
// against it. Random input gaps and output stalls are on in some phases. The
// black level is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
  import afpni_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BOTTOM    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST = 3'd7;
  localparam int  DRAIN_CYCLES  = 64;
  localparam int  LIMIT_CYCLES  = 600000;
  localparam int  N_PHASES      = 7;
  localparam int  PHASE_ITEMS   = 200;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SMP_W-1:0]  red;
    logic [SMP_W-1:0]  green;
    logic [SMP_W-1:0]  blue;
    bit                hold;
  } pixel_t;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [SMP_W-1:0] blue;
    logic             dark;
  } repaired_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [PIX_W-1:0]  cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // red_in, green_in, blue_in
  logic [2:0]        in_tuser = '0;   // kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;       // red_out, green_out, blue_out, zero pad
  logic [0:0]        out_tuser;       // dark_path

  af_pixel_neighbor_interpolate_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0] black_lvl = '0;
  logic [SMP_W-1:0] ctr_red = '0, ctr_green = '0, ctr_blue = '0;
  logic [SMP_W-1:0] near_red = '0, near_green = '0, near_blue = '0, near_dist = '0;

  pixel_t    pixel_q[$];
  repaired_t repaired_q[$];
  pixel_t    cur_pixel;
  int        pending_cnt = 0;
  int        in_gap = 0;
  int        out_stall = 0;
  bit        gaps_on = 1'b0;
  bit        stalls_on = 1'b0;
  int        mismatches = 0;
  int        n_requests = 0;
  int        n_results = 0;
  int        n_dark = 0;
  int        n_blacks = 0;
  int        cycles = 0;

  function automatic logic [PIX_W-1:0] repair_channel(input logic [SMP_W-1:0] v,
                                                      input logic [SMP_W-1:0] pf,
                                                      input logic dark);
    longint b, dv, dl, dn, num, q;
    b  = longint'(black_lvl);
    dv = longint'(v) - b;
    if (dark) begin
      q = dv * 4 + b;
    end else begin
      dl  = longint'(ctr_blue) - b;
      dn  = longint'(near_blue) - b;
      num = 4 * (longint'(pf) - b) * dn + (15 * dv + 8 * b) * dl;
      q   = num / (8 * dl);
    end
    if (q < 0) return '0;
    if (q > longint'(PIX_MAX)) return PIX_MAX;
    return q[PIX_W-1:0];
  endfunction

  function automatic void accept_pixel(input pixel_t p);
    logic [SMP_W-1:0] d;
    logic             dark;
    repaired_t        r;
    if (p.kind > KIND_RIGHT) return;
    if (p.kind == KIND_CENTRE) begin
      ctr_red   = p.red;
      ctr_green = p.green;
      ctr_blue  = p.blue;
      return;
    end
    d = (p.blue > ctr_blue) ? p.blue - ctr_blue : ctr_blue - p.blue;
    if (p.kind == KIND_TOP || near_dist > d) begin
      near_red   = p.red;
      near_green = p.green;
      near_blue  = p.blue;
      near_dist  = d;
    end
    if (p.kind != KIND_RIGHT) return;
    dark    = (ctr_blue < black_lvl + 16) || (near_blue < black_lvl + 16);
    r.red   = repair_channel(ctr_red, near_red, dark);
    r.green = repair_channel(ctr_green, near_green, dark);
    r.blue  = ctr_blue;
    r.dark  = dark;
    repaired_q.push_back(r);
  endfunction

  function automatic int draw_gap();
    return $urandom_range(0, 16);
  endfunction

  // request driver
  always @(posedge clk) begin : drive_blk
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        accept_pixel(cur_pixel);
        pending_cnt--;
        n_requests++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (pixel_q.size() != 0 && !(pixel_q[0].hold && repaired_q.size() != 0)) begin
          cur_pixel = pixel_q.pop_front();
          in_tuser  <= cur_pixel.kind;
          in_tdata  <= {cur_pixel.blue, cur_pixel.green, cur_pixel.red};
          in_gap    <= gaps_on ? draw_gap() : 0;
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_blk
    repaired_t want;
    int        nst;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      nst = out_stall;
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tuser[0]) n_dark++;
        if (repaired_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result r=%0d g=%0d b=%0d dark=%0d", out_tdata[13:0],
                     out_tdata[27:14], out_tdata[43:28], out_tuser[0]);
        end else begin
          want = repaired_q.pop_front();
          if (out_tdata[13:0] !== want.red || out_tdata[27:14] !== want.green ||
              out_tdata[43:28] !== want.blue || out_tuser[0] !== want.dark) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected r=%0d g=%0d b=%0d dark=%0d,",
                        " got r=%0d g=%0d b=%0d dark=%0d"},
                       want.red, want.green, want.blue, want.dark, out_tdata[13:0],
                       out_tdata[27:14], out_tdata[43:28], out_tuser[0]);
          end
        end
        nst = stalls_on ? draw_gap() : 0;
      end else if (nst != 0) begin
        nst--;
      end
      out_stall <= nst;
      out_tready <= (nst == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void push_pixel(input logic [KIND_W-1:0] kind, input logic [SMP_W-1:0] red,
                                     input logic [SMP_W-1:0] green, input logic [SMP_W-1:0] blue,
                                     input bit hold);
    pixel_t p;
    p.kind  = kind;
    p.red   = red;
    p.green = green;
    p.blue  = blue;
    p.hold  = hold;
    pixel_q.push_back(p);
    pending_cnt++;
  endfunction

  function automatic logic [SMP_W-1:0] draw_sample();
    int s;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: begin
        s = int'(black_lvl) + $urandom_range(0, 48) - 16;
        if (s < 0) s = 0;
        return s[SMP_W-1:0];
      end
      2: return 16'($urandom_range(0, 20000));
      default: return 16'($urandom());
    endcase
  endfunction

  // neighbor blue: often a few codes off the center so ties and close calls happen
  function automatic logic [SMP_W-1:0] draw_neighbor_blue(input logic [SMP_W-1:0] cb);
    int s;
    if ($urandom_range(0, 2) != 0) return draw_sample();
    s = int'(cb) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 3));
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return s[SMP_W-1:0];
  endfunction

  task automatic wait_idle();
    while (pending_cnt != 0 || repaired_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_black(input logic [PIX_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    black_lvl = v;
    n_blacks++;
  endtask

  task automatic random_phase(input int n_items, input bit pause_once);
    logic [KIND_W-1:0] nbr_kinds[4];
    logic [KIND_W-1:0] k;
    logic [SMP_W-1:0]  cb;
    int                made, i, skip;
    bit                hold;
    nbr_kinds = '{KIND_TOP, KIND_BOTTOM, KIND_LEFT, KIND_RIGHT};
    made = 0;
    hold = pause_once;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        cb = draw_sample();
        push_pixel(KIND_CENTRE, draw_sample(), draw_sample(), cb,
                   hold || $urandom_range(0, 39) == 0);
        hold = 1'b0;
        for (i = 0; i < 4; i++)
          push_pixel(nbr_kinds[i], draw_sample(), draw_sample(), draw_neighbor_blue(cb), 1'b0);
        made += 5;
      end else if ($urandom_range(0, 1) == 0) begin
        k = KIND_W'($urandom_range(KIND_CENTRE, KIND_RSVD_LAST));
        push_pixel(k, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
        if (k <= KIND_RIGHT) made++;
      end else begin
        // broken group: one member dropped
        skip = $urandom_range(0, 4);
        cb = draw_sample();
        if (skip != 0) push_pixel(KIND_CENTRE, draw_sample(), draw_sample(), cb, 1'b0);
        for (i = 0; i < 4; i++)
          if (skip != i + 1)
            push_pixel(nbr_kinds[i], draw_sample(), draw_sample(), draw_neighbor_blue(cb), 1'b0);
        made += 4;
      end
    end
  endtask

  int               black_plan[N_PHASES] = '{16383, 0, 64, 1000, 0, 4095, 16};
  logic [PIX_W-1:0] next_black;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // right neighbor straight after reset, then ignored kinds
    push_pixel(KIND_RIGHT, 16'd1234, 16'd4321, 16'd500, 1'b0);
    push_pixel(KIND_W'(KIND_RIGHT + 1), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_pixel(KIND_W'(KIND_RIGHT + 2), 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_pixel(KIND_RSVD_LAST, 16'hA5A5, 16'h5A5A, 16'hFFFF, 1'b0);
    // extremes, exact match then tie kept by the earlier neighbor, clip high
    push_pixel(KIND_CENTRE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_pixel(KIND_TOP, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_pixel(KIND_BOTTOM, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    push_pixel(KIND_LEFT, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    push_pixel(KIND_RIGHT, 16'd1, 16'd1, 16'd1, 1'b0);
    // tie between top and bottom
    push_pixel(KIND_CENTRE, 16'd100, 16'd200, 16'd1000, 1'b0);
    push_pixel(KIND_TOP, 16'd5000, 16'd6000, 16'd1010, 1'b0);
    push_pixel(KIND_BOTTOM, 16'd7000, 16'd8000, 16'd990, 1'b0);
    push_pixel(KIND_LEFT, 16'd0, 16'd0, 16'd2000, 1'b0);
    push_pixel(KIND_RIGHT, 16'hFFFF, 16'hFFFF, 16'd3000, 1'b0);
    // dark neighbor chosen
    push_pixel(KIND_CENTRE, 16'd3000, 16'd3000, 16'd5000, 1'b0);
    push_pixel(KIND_TOP, 16'd100, 16'd100, 16'd10, 1'b0);
    push_pixel(KIND_BOTTOM, 16'd0, 16'd0, 16'd0, 1'b0);
    push_pixel(KIND_LEFT, 16'd0, 16'd0, 16'd12, 1'b0);
    push_pixel(KIND_RIGHT, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    // dark center, short group
    push_pixel(KIND_CENTRE, 16'd16383, 16'd0, 16'd15, 1'b0);
    push_pixel(KIND_TOP, 16'hFFFF, 16'hFFFF, 16'd15, 1'b0);
    push_pixel(KIND_RIGHT, 16'd7, 16'd9, 16'd40000, 1'b0);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      next_black = (p == 4) ? PIX_W'($urandom_range(0, 16383)) : PIX_W'(black_plan[p]);
      set_black(next_black);
      gaps_on   = (p % 3) != 2;
      stalls_on = (p % 3) != 1;
      random_phase(PHASE_ITEMS, p == 1);
      wait_idle();
    end

    $display("sent %0d pixel requests, checked %0d repaired results (%0d on the dark path)",
             n_requests, n_results, n_dark);
    $display("black level rewritten %0d times, extremes 0 and 16383 included", n_blacks);
    if (mismatches == 0 && repaired_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: af_pixel_neighbor_interpolate_unit.f
rtl/afpni_pkg.sv
rtl/afpni_ctrl.sv
rtl/afpni_dp.sv
rtl/af_pixel_neighbor_interpolate_unit.sv
tb/tb.sv
